// ===== rtl/core/size_class_bitmap_run_allocator_macros.svh =====
// Assertion macros for the allocator's checker.
// No dependencies; include by bare file name.
`ifndef SIZE_CLASS_BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BITMAP_RUN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define SCBRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scbra: same-cycle check failed");

// Next-cycle implication, off while reset is low.
`define SCBRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scbra: next-cycle check failed");

`endif

// ===== rtl/core/scbra_pkg.sv =====
// Types and constants for the size-class bitmap run allocator.
// No dependencies; used by every module in rtl/core.
package scbra_pkg;

  localparam int BLOCKS_PER_SLAB = 64;
  localparam int NUM_CLASSES     = 8;
  localparam int GRAN_SHIFT_MIN  = 3;
  localparam int SCAN_DIGIT      = 4;   // map bits examined per scan cycle

  localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int BLK_IDX_W = $clog2(BLOCKS_PER_SLAB);
  localparam int CNT_W     = $clog2(BLOCKS_PER_SLAB + 1);
  localparam int HDR_W     = 7;
  localparam int TOTAL_W   = 17;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RUN  = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] size_bytes;
    logic [2:0]  class_index;
    logic [5:0]  block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  class_out;
    logic [5:0]  block_start;
    logic [15:0] data_offset;
  } rsp_t;

  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [BLK_IDX_W-1:0] start;
  } scan_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOTAL,
    S_CLASS,
    S_NEED,
    S_SCAN,
    S_MARK,
    S_OUT
  } state_t;

endpackage

// ===== rtl/core/scbra_scan.sv =====
// First-fit free-run search over one slab bitmap, SCAN_DIGIT bits per cycle.
// Depends on scbra_pkg.
module scbra_scan (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [scbra_pkg::BLOCKS_PER_SLAB-1:0] map,
  input  logic [scbra_pkg::CNT_W-1:0]          need,
  output scbra_pkg::scan_rsp_t                 rsp
);

  logic [scbra_pkg::BLOCKS_PER_SLAB-1:0] shift_r;
  logic [scbra_pkg::CNT_W:0]             pos_r;
  logic [scbra_pkg::CNT_W-1:0]           run_r;
  logic                                  busy_r;

  logic [scbra_pkg::CNT_W-1:0] run_nxt;
  logic [scbra_pkg::CNT_W:0]   p;
  logic [scbra_pkg::CNT_W:0]   hit_pos;
  logic                        hit;
  logic                        last;

  // Run ends at the first position where the zero count reaches need;
  // that end is lowest exactly when the start is lowest.
  always_comb begin
    run_nxt = run_r;
    hit     = 1'b0;
    hit_pos = '0;
    p       = '0;
    for (int j = 0; j < scbra_pkg::SCAN_DIGIT; j++) begin
      p = pos_r + (scbra_pkg::CNT_W + 1)'(j);
      if (!hit) begin
        if (shift_r[j] || p >= (scbra_pkg::CNT_W + 1)'(scbra_pkg::BLOCKS_PER_SLAB)) begin
          run_nxt = '0;
        end else begin
          run_nxt = run_nxt + 1'b1;
        end
        if (run_nxt == need) begin
          hit     = 1'b1;
          hit_pos = p;
        end
      end
    end
  end

  assign last = (pos_r + (scbra_pkg::CNT_W + 1)'(scbra_pkg::SCAN_DIGIT))
                >= (scbra_pkg::CNT_W + 1)'(scbra_pkg::BLOCKS_PER_SLAB);

  assign rsp.done  = busy_r && (hit || last);
  assign rsp.found = hit;
  assign rsp.start = scbra_pkg::BLK_IDX_W'(hit_pos + 1'b1 - {1'b0, need});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (rsp.done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= map;
      pos_r   <= '0;
      run_r   <= '0;
    end else if (busy_r) begin
      shift_r <= shift_r >> scbra_pkg::SCAN_DIGIT;
      pos_r   <= pos_r + (scbra_pkg::CNT_W + 1)'(scbra_pkg::SCAN_DIGIT);
      run_r   <= run_nxt;
    end
  end

endmodule

// ===== rtl/core/size_class_bitmap_run_allocator.sv =====
// Size-class bitmap run allocator: top level with slab bitmaps and control.
// Depends on scbra_pkg and scbra_scan.
//
// Usage:
//   in_*  : allocate or free requests, valid/ready. in_ready is high only
//           while the block is idle; one request is worked at a time.
//   out_* : one result per request, valid/ready, held in an output register,
//           so a new request is taken while a result waits to be read.
//   cfg_* : header_bytes write, taken on any cycle cfg_wr_en is high; write
//           it only while no request is in flight.
// Steps (accept to out_valid): S_TOTAL, S_CLASS, S_NEED, then S_SCAN for an
//   allocate that fits a slab, S_MARK for a found run or a valid free, and
//   S_OUT; an oversized allocate, a miss and a rejected free skip S_MARK. The
//   first-fit search in scbra_scan examines 4 map bits per cycle.
// A new request is taken only after the previous one leaves S_OUT.
// Reset (synchronous, rst_n low): all slabs free, header_bytes = 16, no
//   result pending.
// Receiver stall: the finished result waits in the output register; the next
//   request still runs and holds in its last state until the register frees.
module size_class_bitmap_run_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  scbra_pkg::req_t                in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output scbra_pkg::rsp_t                out_data,
  input  logic                           cfg_wr_en,
  input  logic [scbra_pkg::HDR_W-1:0]    cfg_wr_data
);

  localparam int B = scbra_pkg::BLOCKS_PER_SLAB;

  scbra_pkg::state_t state_r, state_nxt;

  scbra_pkg::req_t                  req_r;
  scbra_pkg::rsp_t                  res_r;
  scbra_pkg::rsp_t                  out_data_r;
  logic                             out_valid_r;
  logic [scbra_pkg::HDR_W-1:0]      hdr_r;
  logic [scbra_pkg::TOTAL_W-1:0]    total_r;
  logic [scbra_pkg::CLS_W-1:0]      cls_r;
  logic [scbra_pkg::CNT_W-1:0]      need_r;
  logic [scbra_pkg::BLK_IDX_W-1:0]  start_r;
  logic [B-1:0]                     map_r [scbra_pkg::NUM_CLASSES];

  logic                             scan_start;
  scbra_pkg::scan_rsp_t             scan_rsp;
  logic                             out_free;
  logic                             is_alloc;

  logic [scbra_pkg::TOTAL_W-1:0]    total_calc;
  logic [scbra_pkg::CLS_W-1:0]      cls_calc;
  logic [3:0]                       gran_shift;
  logic [scbra_pkg::TOTAL_W:0]      round_sum;
  logic [scbra_pkg::TOTAL_W:0]      n_raw;
  logic [scbra_pkg::TOTAL_W:0]      n_blocks;
  logic                             too_big;
  logic                             free_ok;
  logic [scbra_pkg::CNT_W-1:0]      room;
  logic [scbra_pkg::CNT_W-1:0]      need_calc;
  logic [B-1:0]                     run_mask;
  logic [15:0]                      offset_calc;

  assign is_alloc = (req_r.op == scbra_pkg::OP_ALLOC);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == scbra_pkg::S_IDLE);

  // size rounded up to 8, plus header
  assign total_calc = ({1'b0, req_r.size_bytes[15:3], 3'b000}
                       + {13'd0, (|req_r.size_bytes[2:0]), 3'b000})
                      + scbra_pkg::TOTAL_W'(hdr_r);

  always_comb begin
    cls_calc = '0;
    for (int k = 1; k < scbra_pkg::NUM_CLASSES; k++) begin
      if (total_r >= (scbra_pkg::TOTAL_W'(1) << (scbra_pkg::GRAN_SHIFT_MIN + k))) begin
        cls_calc = scbra_pkg::CLS_W'(k);
      end
    end
  end

  assign gran_shift = 4'(scbra_pkg::GRAN_SHIFT_MIN) + 4'(cls_r);
  assign round_sum  = {1'b0, total_r}
                      + (((scbra_pkg::TOTAL_W + 1)'(1) << gran_shift) - 1'b1);
  assign n_raw      = round_sum >> gran_shift;
  assign n_blocks   = (n_raw == '0) ? (scbra_pkg::TOTAL_W + 1)'(1) : n_raw;
  assign too_big    = n_blocks > (scbra_pkg::TOTAL_W + 1)'(B);

  assign free_ok = ({1'b0, req_r.class_index} < 4'(scbra_pkg::NUM_CLASSES))
                && ((scbra_pkg::CNT_W + 1)'(req_r.block_index)
                    < (scbra_pkg::CNT_W + 1)'(B));
  assign room    = scbra_pkg::CNT_W'(B) - scbra_pkg::CNT_W'(req_r.block_index);

  always_comb begin
    if (is_alloc) begin
      need_calc = scbra_pkg::CNT_W'(n_blocks);
    end else if (n_blocks > (scbra_pkg::TOTAL_W + 1)'(room)) begin
      need_calc = room;
    end else begin
      need_calc = scbra_pkg::CNT_W'(n_blocks);
    end
  end

  always_comb begin
    for (int i = 0; i < B; i++) begin
      run_mask[i] = ((scbra_pkg::CNT_W + 1)'(i) >= (scbra_pkg::CNT_W + 1)'(start_r))
                 && (((scbra_pkg::CNT_W + 1)'(i) - (scbra_pkg::CNT_W + 1)'(start_r))
                     < (scbra_pkg::CNT_W + 1)'(need_r));
    end
  end

  assign offset_calc = 16'(32'(start_r) << (scbra_pkg::GRAN_SHIFT_MIN + 32'(cls_r)))
                       + 16'(hdr_r);

  scbra_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .map   (map_r[cls_r]),
    .need  (need_r),
    .rsp   (scan_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scbra_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    scan_start = 1'b0;
    unique case (state_r)
      scbra_pkg::S_IDLE: begin
        if (in_valid) state_nxt = scbra_pkg::S_TOTAL;
      end
      scbra_pkg::S_TOTAL: state_nxt = scbra_pkg::S_CLASS;
      scbra_pkg::S_CLASS: state_nxt = scbra_pkg::S_NEED;
      scbra_pkg::S_NEED: begin
        if (is_alloc) begin
          if (too_big) begin
            state_nxt = scbra_pkg::S_OUT;
          end else begin
            scan_start = 1'b1;
            state_nxt  = scbra_pkg::S_SCAN;
          end
        end else begin
          state_nxt = free_ok ? scbra_pkg::S_MARK : scbra_pkg::S_OUT;
        end
      end
      scbra_pkg::S_SCAN: begin
        if (scan_rsp.done) begin
          state_nxt = scan_rsp.found ? scbra_pkg::S_MARK : scbra_pkg::S_OUT;
        end
      end
      scbra_pkg::S_MARK: state_nxt = scbra_pkg::S_OUT;
      scbra_pkg::S_OUT: begin
        if (out_free) state_nxt = scbra_pkg::S_IDLE;
      end
      default: state_nxt = scbra_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    case (state_r)
      scbra_pkg::S_TOTAL: total_r <= total_calc;
      scbra_pkg::S_CLASS: begin
        cls_r <= is_alloc ? cls_calc : scbra_pkg::CLS_W'(req_r.class_index);
      end
      scbra_pkg::S_NEED: begin
        need_r            <= need_calc;
        start_r           <= scbra_pkg::BLK_IDX_W'(req_r.block_index);
        res_r.status      <= (is_alloc && too_big) ? scbra_pkg::ST_TOO_BIG
                                                   : scbra_pkg::ST_OK;
        res_r.class_out   <= is_alloc ? 3'(cls_r) : 3'd0;
        res_r.block_start <= '0;
        res_r.data_offset <= '0;
      end
      scbra_pkg::S_SCAN: begin
        if (scan_rsp.done) begin
          if (scan_rsp.found) begin
            start_r <= scan_rsp.start;
          end else begin
            res_r.status <= scbra_pkg::ST_NO_RUN;
          end
        end
      end
      scbra_pkg::S_MARK: begin
        if (is_alloc) begin
          res_r.block_start <= 6'(start_r);
          res_r.data_offset <= offset_calc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < scbra_pkg::NUM_CLASSES; c++) map_r[c] <= '0;
    end else if (state_r == scbra_pkg::S_MARK) begin
      if (is_alloc) begin
        map_r[cls_r] <= map_r[cls_r] | run_mask;
      end else begin
        map_r[cls_r] <= map_r[cls_r] & ~run_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= scbra_pkg::HDR_W'(16);
    end else if (cfg_wr_en) begin
      hdr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == scbra_pkg::S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == scbra_pkg::S_OUT && out_free) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/scbra_checker.sv =====
// Port-level checks for the allocator, bound to its top level.
// Depends on scbra_pkg and size_class_bitmap_run_allocator_macros.svh.
`include "size_class_bitmap_run_allocator_macros.svh"

module scbra_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input scbra_pkg::req_t             in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input scbra_pkg::rsp_t             out_data,
  input logic                        cfg_wr_en,
  input logic [scbra_pkg::HDR_W-1:0] cfg_wr_data
);

  logic cfg_seen;
  logic req_seen;

  assign cfg_seen = cfg_wr_en && (cfg_wr_data == cfg_wr_data);
  assign req_seen = in_valid && in_ready && (in_data == in_data);

  // a stalled result holds
  `SCBRA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // one request at a time: busy right after an accept
  `SCBRA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_seen || (in_valid && in_ready), !in_ready)

  // failed allocations report no block and no offset
  `SCBRA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && (out_data.status != scbra_pkg::ST_OK), (out_data.block_start == 6'd0) && (out_data.data_offset == 16'd0))

  // only the top class can overflow a slab
  `SCBRA_ASSERT_IMP(a_too_big_top, clk, rst_n, out_valid && (out_data.status == scbra_pkg::ST_TOO_BIG) && !cfg_seen, out_data.class_out == 3'(scbra_pkg::NUM_CLASSES - 1))

endmodule

bind size_class_bitmap_run_allocator scbra_checker u_scbra_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_data     (in_data),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);
